>>> hw/rtl/bpmb_pkg.sv
// Shared types and constants of the button power, mode and blink unit.
package bpmb_pkg;

   localparam int unsigned NOW_WIDTH = 32;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 16;
   localparam int unsigned TIME_WIDTH = 15;
   localparam int unsigned PERIOD_WIDTH = 16;
   localparam int unsigned COUNT_WIDTH = 5;

   localparam logic [1:0] MODE_FIRST = 2'd0;
   localparam logic [1:0] MODE_SECOND = 2'd1;
   localparam logic [1:0] MODE_LAST = 2'd2;
   localparam logic [COUNT_WIDTH-1:0] DIV_LAST_STEP = 5'd31;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd10;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd3000;
   localparam logic [14:0] TIME_A_RESET = 15'd200;
   localparam logic [14:0] TIME_B_RESET = 15'd400;
   localparam logic [14:0] TIME_C_RESET = 15'd600;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DEBOUNCE   = 3'd0,
      CSR_LONG_PRESS = 3'd1,
      CSR_ON_A       = 3'd2,
      CSR_OFF_A      = 3'd3,
      CSR_ON_B       = 3'd4,
      CSR_OFF_B      = 3'd5,
      CSR_ON_C       = 3'd6,
      CSR_OFF_C      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [NOW_WIDTH-1:0] now_ms;
      logic                 key_level;
   } req_payload_type;

   typedef struct packed {
      logic       led_on;
      logic       power_on;
      logic [1:0] mode;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_THRESH,
      ST_KEY,
      ST_PREP,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic thresh;
      logic key_update;
      logic prep;
      logic div_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_busy;
   } status_type;

endpackage

>>> hw/rtl/bpmb_ctrl.sv
// Controller state machine of the button power, mode and blink unit.
module bpmb_ctrl
   import bpmb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_THRESH;
            end
         end
         ST_THRESH: state_in = ST_KEY;
         ST_KEY:    state_in = ST_PREP;
         ST_PREP:   state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
         end
         ST_THRESH: cmd.thresh = 1'b1;
         ST_KEY:    cmd.key_update = 1'b1;
         ST_PREP:   cmd.prep = 1'b1;
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_EMIT:   cmd.emit = !status.out_busy;
         default:   cmd = '0;
      endcase
   end

endmodule

>>> hw/rtl/bpmb_dp.sv
// Datapath: settings, button tracking, restoring divider and result register.
module bpmb_dp
   import bpmb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  req_payload_type            req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_payload_type            rsp_data,
   input  cmd_type                    cmd,
   output status_type                 status
);

   // Settings.
   logic [15:0]           debounce_ff;
   logic [15:0]           long_press_ff;
   logic [TIME_WIDTH-1:0] on_a_ff, off_a_ff, on_b_ff, off_b_ff, on_c_ff, off_c_ff;

   // Button state.
   logic                 last_level_ff, last_level_in;
   logic [NOW_WIDTH-1:0] deb_start_ff, deb_start_in;
   logic [NOW_WIDTH-1:0] press_start_ff, press_start_in;
   logic                 pressing_ff, pressing_in;
   logic                 long_fired_ff, long_fired_in;
   logic                 power_ff, power_in;
   logic [1:0]           mode_ff, mode_in;

   // Captured request and thresholds.
   logic [NOW_WIDTH-1:0] now_ff;
   logic                 level_ff;
   logic [NOW_WIDTH-1:0] deb_thr_ff;
   logic [NOW_WIDTH-1:0] long_thr_ff;

   // Divider.
   logic [PERIOD_WIDTH-1:0] period_ff;
   logic [TIME_WIDTH-1:0]   on_ff;
   logic [PERIOD_WIDTH-1:0] rem_ff, rem_in;
   logic [NOW_WIDTH-1:0]    dividend_ff;
   logic [COUNT_WIDTH-1:0]  count_ff;
   logic [PERIOD_WIDTH:0]   shifted;

   // Result register.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   logic [NOW_WIDTH-1:0]    deb_diff, long_diff;
   logic                    deb_passed, long_passed;
   logic [TIME_WIDTH-1:0]   sel_on, sel_off;
   logic                    led_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         long_press_ff <= LONG_PRESS_RESET;
         on_a_ff       <= TIME_A_RESET;
         off_a_ff      <= TIME_A_RESET;
         on_b_ff       <= TIME_B_RESET;
         off_b_ff      <= TIME_B_RESET;
         on_c_ff       <= TIME_C_RESET;
         off_c_ff      <= TIME_C_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEBOUNCE:   debounce_ff   <= csr_wdata;
            CSR_LONG_PRESS: long_press_ff <= csr_wdata;
            CSR_ON_A:       on_a_ff       <= csr_wdata[TIME_WIDTH-1:0];
            CSR_OFF_A:      off_a_ff      <= csr_wdata[TIME_WIDTH-1:0];
            CSR_ON_B:       on_b_ff       <= csr_wdata[TIME_WIDTH-1:0];
            CSR_OFF_B:      off_b_ff      <= csr_wdata[TIME_WIDTH-1:0];
            CSR_ON_C:       on_c_ff       <= csr_wdata[TIME_WIDTH-1:0];
            CSR_OFF_C:      off_c_ff      <= csr_wdata[TIME_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // A time lies strictly after a threshold when the difference is nonzero
   // and positive as a signed 32-bit value.
   assign deb_diff    = now_ff - deb_thr_ff;
   assign long_diff   = now_ff - long_thr_ff;
   assign deb_passed  = (deb_diff != '0) && !deb_diff[NOW_WIDTH-1];
   assign long_passed = (long_diff != '0) && !long_diff[NOW_WIDTH-1];

   always_comb begin
      last_level_in  = last_level_ff;
      deb_start_in   = deb_start_ff;
      press_start_in = press_start_ff;
      pressing_in    = pressing_ff;
      long_fired_in  = long_fired_ff;
      power_in       = power_ff;
      mode_in        = mode_ff;
      if (cmd.key_update) begin
         if (level_ff != last_level_ff) begin
            last_level_in = level_ff;
            deb_start_in  = now_ff;
         end else if (deb_passed) begin
            if (!pressing_ff && !level_ff) begin
               pressing_in    = 1'b1;
               press_start_in = now_ff;
               long_fired_in  = 1'b0;
            end else if (!long_fired_ff && !level_ff && pressing_ff) begin
               if (long_passed) begin
                  long_fired_in = 1'b1;
                  power_in      = !power_ff;
               end
            end else if (level_ff && pressing_ff) begin
               if (!long_fired_ff && power_ff) begin
                  mode_in = (mode_ff == MODE_LAST) ? MODE_FIRST : mode_ff + 2'd1;
               end
               pressing_in   = 1'b0;
               long_fired_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff  <= 1'b1;
         deb_start_ff   <= '0;
         press_start_ff <= '0;
         pressing_ff    <= 1'b0;
         long_fired_ff  <= 1'b0;
         power_ff       <= 1'b0;
         mode_ff        <= MODE_FIRST;
      end else begin
         last_level_ff  <= last_level_in;
         deb_start_ff   <= deb_start_in;
         press_start_ff <= press_start_in;
         pressing_ff    <= pressing_in;
         long_fired_ff  <= long_fired_in;
         power_ff       <= power_in;
         mode_ff        <= mode_in;
      end
   end

   always_comb begin
      case (mode_ff)
         MODE_SECOND: begin
            sel_on  = on_b_ff;
            sel_off = off_b_ff;
         end
         MODE_LAST: begin
            sel_on  = on_c_ff;
            sel_off = off_c_ff;
         end
         default: begin
            sel_on  = on_a_ff;
            sel_off = off_a_ff;
         end
      endcase
   end

   // One quotient bit per cycle; the remainder stays below the period whenever the period is nonzero.
   assign shifted = {rem_ff, dividend_ff[NOW_WIDTH-1]};
   always_comb begin
      if (shifted >= {1'b0, period_ff}) begin
         rem_in = PERIOD_WIDTH'(shifted - {1'b0, period_ff});
      end else begin
         rem_in = shifted[PERIOD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         now_ff   <= req_data.now_ms;
         level_ff <= req_data.key_level;
      end
      if (cmd.thresh) begin
         deb_thr_ff  <= deb_start_ff + {16'd0, debounce_ff};
         long_thr_ff <= press_start_ff + {16'd0, long_press_ff};
      end
      if (cmd.prep) begin
         period_ff   <= {1'b0, sel_on} + {1'b0, sel_off};
         on_ff       <= sel_on;
         rem_ff      <= '0;
         dividend_ff <= now_ff;
         count_ff    <= '0;
      end else if (cmd.div_step) begin
         rem_ff      <= rem_in;
         dividend_ff <= {dividend_ff[NOW_WIDTH-2:0], 1'b0};
         count_ff    <= count_ff + 1'b1;
      end
   end

   assign led_level = power_ff && (period_ff != '0) && (rem_ff < {1'b0, on_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.led_on   <= led_level;
         rsp_data_ff.power_on <= power_ff;
         rsp_data_ff.mode     <= mode_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign status.div_last = (count_ff == DIV_LAST_STEP);
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

endmodule

>>> hw/rtl/button_power_mode_blinker_unit.sv
// Top level of the button power, mode and blink unit.
//
// Each request carries one button sample: a free-running millisecond
// timestamp and the active-low key level. The unit debounces the level,
// toggles power on a long press and advances the blink mode on a short
// press while power is on. Every request yields exactly one response with
// the power flag, the mode and the LED level for that timestamp.
// Both channels use valid and ready. One request is worked on at a time:
// after acceptance the unit forms the time thresholds, updates the button
// state, picks the blink period, and runs a restoring divider over all 32
// timestamp bits that produces the timestamp modulo the period one bit per
// cycle. The result is then loaded into the response register, and only
// after that can a new request be accepted.
// The response sits in an output register, so the next request is taken
// while it waits; if the receiver still stalls when the following result
// is done, the unit holds it and does not accept further requests.
// The settings port writes one register per cycle without handshake.
// Synchronous reset restores the default settings, releases the button,
// turns power off and selects mode zero.
module button_power_mode_blinker_unit
   import bpmb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_payload_type            req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_payload_type            rsp_data,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // Sequencer of the per-request steps.
   bpmb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Settings, button state, divider and the response register.
   bpmb_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .cmd          (cmd),
      .status       (status)
   );

endmodule

>>> hw/rtl/bpmb_checker.sv
// Port-level checks of the button power, mode and blink unit, with its bind.
module bpmb_checker
   import bpmb_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // The mode never reaches the unused code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.mode != 2'd3)
      else $error("mode out of range");

   // The LED stays dark while power is off.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.power_on |-> !rsp_data.led_on)
      else $error("LED lit with power off");

   // Reset empties the response register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // An accepted request keeps the unit busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in progress");

endmodule

bind button_power_mode_blinker_unit bpmb_checker u_bpmb_checker (.*);

>>> dv/tb_button_power_mode_blinker_unit.sv
// Self-checking testbench for the button power, mode and blink unit.
`timescale 1ns / 1ps

module tb_button_power_mode_blinker_unit;
   import bpmb_pkg::*;

   // The run stops with a failure if it ever gets this far.
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned PHASE_COUNT = 8;
   localparam int unsigned PHASE_REQUESTS = 200;
   localparam int unsigned DRAIN_CYCLES = 40;

   // Kinds of register settings that the random phases cycle through.
   typedef enum {
      SET_SHORT,
      SET_MINIMUM,
      SET_MAXIMUM,
      SET_ANY
   } setting_kind_type;

   // Scoreboard: it keeps its own copy of the button state and of the
   // settings, predicts one response per accepted request, and compares
   // every response the unit delivers with the oldest prediction.
   class blink_scoreboard;
      logic [15:0] debounce_ms;
      logic [15:0] long_press_ms;
      logic [14:0] on_ms [3];
      logic [14:0] off_ms [3];

      logic        level_q;
      logic [31:0] change_ms;
      logic [31:0] press_ms;
      logic        pressing;
      logic        long_done;
      logic        power;
      logic [1:0]  mode;

      rsp_payload_type expected_blinks [$];
      int unsigned mismatches;
      int unsigned samples;
      int unsigned power_toggles;
      int unsigned mode_steps;

      function new();
         debounce_ms = DEBOUNCE_RESET;
         long_press_ms = LONG_PRESS_RESET;
         on_ms[MODE_FIRST] = TIME_A_RESET;
         off_ms[MODE_FIRST] = TIME_A_RESET;
         on_ms[MODE_SECOND] = TIME_B_RESET;
         off_ms[MODE_SECOND] = TIME_B_RESET;
         on_ms[MODE_LAST] = TIME_C_RESET;
         off_ms[MODE_LAST] = TIME_C_RESET;
         level_q = 1'b1;
         change_ms = '0;
         press_ms = '0;
         pressing = 1'b0;
         long_done = 1'b0;
         power = 1'b0;
         mode = MODE_FIRST;
         mismatches = 0;
         samples = 0;
         power_toggles = 0;
         mode_steps = 0;
      endfunction

      // The on and off time registers are 15 bits wide; higher bits are dropped.
      function void apply_setting(csr_index_type idx, logic [15:0] value);
         case (idx)
            CSR_DEBOUNCE:   debounce_ms = value;
            CSR_LONG_PRESS: long_press_ms = value;
            CSR_ON_A:       on_ms[MODE_FIRST] = value[14:0];
            CSR_OFF_A:      off_ms[MODE_FIRST] = value[14:0];
            CSR_ON_B:       on_ms[MODE_SECOND] = value[14:0];
            CSR_OFF_B:      off_ms[MODE_SECOND] = value[14:0];
            CSR_ON_C:       on_ms[MODE_LAST] = value[14:0];
            CSR_OFF_C:      off_ms[MODE_LAST] = value[14:0];
            default: ;
         endcase
      endfunction

      // True when a lies strictly after b, with the difference taken as a
      // signed 32-bit value so that the timestamp may wrap.
      function bit later_than(logic [31:0] a, logic [31:0] b);
         logic [31:0] diff;
         diff = a - b;
         return diff != '0 && !diff[31];
      endfunction

      function void predict_sample(req_payload_type req);
         rsp_payload_type want;
         logic [15:0]     period;
         samples++;
         if (req.key_level != level_q) begin
            level_q = req.key_level;
            change_ms = req.now_ms;
         end else if (later_than(req.now_ms, change_ms + {16'b0, debounce_ms})) begin
            if (!pressing && !req.key_level) begin
               pressing = 1'b1;
               press_ms = req.now_ms;
               long_done = 1'b0;
            end else if (!long_done && !req.key_level && pressing) begin
               if (later_than(req.now_ms, press_ms + {16'b0, long_press_ms})) begin
                  long_done = 1'b1;
                  power = !power;
                  power_toggles++;
               end
            end else if (req.key_level && pressing) begin
               if (!long_done && power) begin
                  mode = (mode == MODE_LAST) ? MODE_FIRST : mode + 2'd1;
                  mode_steps++;
               end
               pressing = 1'b0;
               long_done = 1'b0;
            end
         end
         period = {1'b0, on_ms[mode]} + {1'b0, off_ms[mode]};
         want.power_on = power;
         want.mode = mode;
         want.led_on = power && period != '0
            && (req.now_ms % {16'b0, period}) < {17'b0, on_ms[mode]};
         expected_blinks.push_back(want);
      endfunction

      function void compare_field(string name, logic [1:0] want, logic [1:0] got);
         if (got !== want) begin
            $display("%0t: %s wrong, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_blink(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_blinks.size() == 0) begin
            $display("%0t: response with no request outstanding, expected none, actual %h",
                     $time, got);
            mismatches++;
            return;
         end
         want = expected_blinks.pop_front();
         compare_field("led_on", {1'b0, want.led_on}, {1'b0, got.led_on});
         compare_field("power_on", {1'b0, want.power_on}, {1'b0, got.power_on});
         compare_field("mode", want.mode, got.mode);
      endfunction

      function int unsigned outstanding();
         return expected_blinks.size();
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_write_en = 1'b0;
   csr_index_type   csr_index = CSR_DEBOUNCE;
   logic [15:0]     csr_wdata = '0;

   blink_scoreboard blink_board = new();

   // Idle chances in percent: per sample on send, per ready draw on receive.
   int unsigned send_idle_pct = 13;
   int unsigned recv_idle_pct = 63;
   int unsigned requests_sent = 0;
   int unsigned cycle_count;
   // Running timestamp that the button gestures advance.
   logic [31:0] sample_ms = '0;

   setting_kind_type phase_setting [PHASE_COUNT] = '{
      SET_SHORT, SET_MINIMUM, SET_SHORT, SET_MAXIMUM,
      SET_ANY, SET_SHORT, SET_ANY, SET_SHORT
   };

   button_power_mode_blinker_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // Response side: every response taken is checked right away, and the
   // ready line is redrawn every cycle to stall the unit at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         blink_board.check_blink(rsp_data);
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
         @(posedge clock);
      end
      $display("button_power_mode_blinker_unit: mismatch");
      $finish;
   end

   // Offers one button sample and returns at the edge where it is taken.
   // Valid is left high afterward so that a back-to-back request keeps it
   // up; whoever pauses next lowers it.
   task automatic send_sample(input logic [31:0] now, input logic level);
      req_payload_type sample;
      sample.now_ms = now;
      sample.key_level = level;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= sample;
      do begin
         @(posedge clock);
      end while (!(req_valid && req_ready));
      blink_board.predict_sample(sample);
      requests_sent++;
   endtask

   // Holds the request side off until every predicted response has come.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (blink_board.outstanding() != 0) @(posedge clock);
   endtask

   // One register write at the next edge. The caller drops the write
   // enable after the last write of a group.
   task automatic write_setting(input csr_index_type idx, input logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      blink_board.apply_setting(idx, value);
   endtask

   // Writes all eight registers for one phase.
   task automatic configure_phase(input setting_kind_type kind);
      logic [15:0]   value;
      csr_index_type idx;
      for (int i = 0; i < 8; i++) begin
         idx = csr_index_type'(i);
         case (kind)
            SET_SHORT: begin
               if (idx == CSR_DEBOUNCE) begin
                  value = 16'($urandom_range(0, 12));
               end else if (idx == CSR_LONG_PRESS) begin
                  value = 16'($urandom_range(0, 250));
               end else begin
                  // The top bit lies outside the 15-bit register and must be dropped.
                  value = {1'($urandom_range(1)), 15'($urandom_range(1, 60))};
               end
            end
            SET_MINIMUM: begin
               value = (idx == CSR_DEBOUNCE || idx == CSR_LONG_PRESS) ? 16'd0 : 16'd1;
            end
            SET_MAXIMUM: begin
               value = (idx == CSR_DEBOUNCE || idx == CSR_LONG_PRESS) ? 16'hFFFF : 16'h7FFF;
            end
            default: begin
               value = 16'($urandom());
            end
         endcase
         write_setting(idx, value);
      end
      csr_write_en <= 1'b0;
   endtask

   // Time step between samples, drawn so that the debounce and long-press
   // thresholds are hit exactly, just missed and clearly passed.
   function automatic logic [31:0] pick_gap();
      logic [31:0] db;
      logic [31:0] lp;
      db = {16'b0, blink_board.debounce_ms};
      lp = {16'b0, blink_board.long_press_ms};
      case ($urandom_range(5))
         0: return $urandom_range(0, 3);
         1: return db + $urandom_range(0, 2);
         2: return lp + $urandom_range(0, 2);
         3: return $urandom_range(0, db + 2);
         default: return $urandom_range(1, lp / 2 + db + 2);
      endcase
   endfunction

   // A press and release with random contact bounce on both ends and a
   // hold that may or may not reach the long-press time.
   task automatic press_gesture();
      repeat ($urandom_range(0, 3)) begin
         sample_ms += $urandom_range(0, 3);
         send_sample(sample_ms, 1'b0);
         sample_ms += $urandom_range(0, 3);
         send_sample(sample_ms, 1'b1);
      end
      repeat ($urandom_range(1, 5)) begin
         sample_ms += pick_gap();
         send_sample(sample_ms, 1'b0);
      end
      repeat ($urandom_range(0, 3)) begin
         sample_ms += $urandom_range(0, 3);
         send_sample(sample_ms, 1'b1);
         sample_ms += $urandom_range(0, 3);
         send_sample(sample_ms, 1'b0);
      end
      repeat ($urandom_range(1, 4)) begin
         sample_ms += pick_gap();
         send_sample(sample_ms, 1'b1);
      end
   endtask

   // Samples with jumps in time, backward steps and random levels.
   task automatic noise_burst();
      repeat ($urandom_range(1, 3)) begin
         case ($urandom_range(2))
            0: sample_ms = $urandom();
            1: sample_ms += $urandom_range(0, 3);
            default: sample_ms -= $urandom_range(1, 50);
         endcase
         send_sample(sample_ms, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      int unsigned target;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part, on the reset settings. A press becomes stable at
      // timestamp zero after a level change just before the wrap; the long
      // press fires one millisecond after its threshold, not at it.
      send_sample(32'd0, 1'b1);
      send_sample(32'hFFFF_FFF0, 1'b0);
      send_sample(32'd0, 1'b0);
      send_sample(32'd3000, 1'b0);
      send_sample(32'd3001, 1'b0);
      // Release after the long press: power is now on and the mode stays.
      // The release is not stable at exactly the debounce time.
      send_sample(32'd3050, 1'b1);
      send_sample(32'd3060, 1'b1);
      send_sample(32'd3061, 1'b1);
      // Three short presses walk the mode all the way round.
      for (int k = 0; k < 3; k++) begin
         send_sample(32'd3100 + 32'(k * 100), 1'b0);
         send_sample(32'd3111 + 32'(k * 100), 1'b0);
         send_sample(32'd3130 + 32'(k * 100), 1'b1);
         send_sample(32'd3141 + 32'(k * 100), 1'b1);
      end
      // Zero on time in mode zero, written with a bit above the register.
      wait_for_responses();
      write_setting(CSR_ON_A, 16'h8000);
      csr_write_en <= 1'b0;
      send_sample(32'd4000, 1'b1);
      // Zero blink period: both times of mode zero cleared.
      wait_for_responses();
      write_setting(CSR_OFF_A, 16'h8000);
      csr_write_en <= 1'b0;
      send_sample(32'd4001, 1'b1);
      send_sample(32'hFFFF_FFFF, 1'b1);
      // Shortest on time against the longest off time, around the wrap.
      wait_for_responses();
      write_setting(CSR_ON_A, 16'd1);
      write_setting(CSR_OFF_A, 16'h7FFF);
      csr_write_en <= 1'b0;
      send_sample(32'hFFFF_FFFF, 1'b1);
      send_sample(32'h0000_8000, 1'b1);

      // Random part: each phase waits for the unit to drain, loads a fresh
      // set of registers and then plays mostly well-formed gestures.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p < 3) begin
            send_idle_pct = 13;
            recv_idle_pct = 63;
         end else if (p < 6) begin
            send_idle_pct = 63;
            recv_idle_pct = 13;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         wait_for_responses();
         configure_phase(phase_setting[p]);
         sample_ms = $urandom();
         target = requests_sent + PHASE_REQUESTS;
         while (requests_sent < target) begin
            if ($urandom_range(99) < 85) begin
               press_gesture();
            end else begin
               noise_burst();
            end
         end
      end

      // Drain, then give any stray response time to show up.
      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d button samples over %0d register settings phases,",
               blink_board.samples, PHASE_COUNT + 1);
      $display("with %0d power toggles and %0d mode steps predicted.",
               blink_board.power_toggles, blink_board.mode_steps);
      if (blink_board.mismatches == 0 && blink_board.outstanding() == 0) begin
         $display("button_power_mode_blinker_unit: match");
      end else begin
         $display("button_power_mode_blinker_unit: mismatch");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/bpmb_pkg.sv
hw/rtl/bpmb_ctrl.sv
hw/rtl/bpmb_dp.sv
hw/rtl/button_power_mode_blinker_unit.sv
hw/rtl/bpmb_checker.sv
dv/tb_button_power_mode_blinker_unit.sv
